// ===== hdl/hrhp_pkg.sv =====
// types, constants and helpers shared by the http response head parser
`default_nettype none

package hrhp_pkg;

  localparam int unsigned LengthBitsDefault = 32;

  localparam logic [4:0] NoMatch = 5'd31;
  localparam logic [4:0] NameLen = 5'd14;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChLowC  = 8'h63;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    PH_SEEK_SPACE = 4'd0,
    PH_STATUS     = 4'd1,
    PH_STATUS_CR  = 4'd2,
    PH_STATUS_LF  = 4'd3,
    PH_HDR_START  = 4'd4,
    PH_HDR_NAME   = 4'd5,
    PH_VAL_START  = 4'd6,
    PH_HDR_VALUE  = 4'd7,
    PH_HDR_LF     = 4'd8,
    PH_BLANK_LF   = 4'd9,
    PH_BODY_START = 4'd10,
    PH_BODY       = 4'd11,
    PH_COMPLETE   = 4'd12,
    PH_ERROR      = 4'd13
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] status_code;
    logic [31:0] length_value;
    logic        is_body_byte;
    logic        last_body_byte;
  } out_item_t;

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // "content-length", lower case
  function automatic logic [7:0] wanted_char(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h63;
      4'd1:    r = 8'h6f;
      4'd2:    r = 8'h6e;
      4'd3:    r = 8'h74;
      4'd4:    r = 8'h65;
      4'd5:    r = 8'h6e;
      4'd6:    r = 8'h74;
      4'd7:    r = 8'h2d;
      4'd8:    r = 8'h6c;
      4'd9:    r = 8'h65;
      4'd10:   r = 8'h6e;
      4'd11:   r = 8'h67;
      4'd12:   r = 8'h74;
      4'd13:   r = 8'h68;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/http_response_head_parser.sv =====
// http/1.1 response head parser, one byte per cycle unless the output stalls
//
//   channel | signals                          | payload
//   in      | in_valid_i / in_ready_o          | in_item_i  (kind, byte_value)
//   out     | out_valid_o / out_ready_i        | out_item_o (phase, status, length, body)
//
// one item per cycle while the output is taken; each byte's result shows in the cycle after it is accepted
// the parse state updates in the accept cycle, the result sits in one output register
// in_ready_o is high while the output register is empty or being taken
// reset returns the parser to the seek-status-space phase with empty output
`default_nettype none

module http_response_head_parser
  import hrhp_pkg::*;
#(
  parameter int unsigned LengthBits = LengthBitsDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_item_t  out_item_o
);

  phase_e                  phase_q, phase_d;
  logic [4:0]              match_q, match_d;
  logic [15:0]             status_q, status_d;
  logic [LengthBits-1:0]   len_q, len_d;
  logic [LengthBits-1:0]   remain_q, remain_d;
  logic                    unlim_q, unlim_d;

  logic                    out_valid_q;
  out_item_t               out_item_q, out_item_d;

  logic                    accept;
  logic [7:0]              b;
  logic [7:0]              b_low;
  logic [3:0]              dval;
  logic                    is_digit;
  logic [19:0]             st_sum;
  logic [15:0]             st_next;
  logic [LengthBits-1:0]   len_base;
  logic [LengthBits+3:0]   len_sum;
  logic [LengthBits-1:0]   len_next;
  logic [LengthBits-1:0]   rem_src;
  logic [LengthBits-1:0]   rem_dec;
  logic [LengthBits+31:0]  len_ext;
  logic                    is_body;
  logic                    is_last;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign b        = in_item_i.byte_value;
  assign b_low    = lower_case(b);
  assign dval     = b[3:0];
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);

  // saturating decimal accumulate
  assign st_sum  = ({4'b0, status_q} << 3) + ({4'b0, status_q} << 1) + {16'b0, dval};
  assign st_next = (st_sum[19:16] != 4'b0) ? '1 : st_sum[15:0];

  assign len_base = ((phase_q == PH_VAL_START) && (match_q == NameLen)) ? '0 : len_q;
  assign len_sum  = ({4'b0, len_base} << 3) + ({4'b0, len_base} << 1)
                  + {{LengthBits{1'b0}}, dval};
  assign len_next = (len_sum[LengthBits+3:LengthBits] != 4'b0) ? '1
                                                             : len_sum[LengthBits-1:0];

  assign rem_src = (phase_q == PH_BODY_START) ? len_q : remain_q;
  assign rem_dec = (rem_src != '0) ? rem_src - 1'b1 : rem_src;

  always_comb begin
    phase_d  = phase_q;
    match_d  = match_q;
    status_d = status_q;
    len_d    = len_q;
    remain_d = remain_q;
    unlim_d  = unlim_q;
    is_body  = 1'b0;
    is_last  = 1'b0;
    if (in_item_i.kind == KIND_RESTART) begin
      phase_d  = PH_SEEK_SPACE;
      match_d  = NoMatch;
      status_d = '0;
      len_d    = '0;
      remain_d = '0;
      unlim_d  = 1'b0;
    end else begin
      unique case (phase_q)
        PH_SEEK_SPACE: begin
          if (b == ChSpace) begin
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (is_digit) begin
            status_d = st_next;
          end else if (b == ChSpace) begin
            phase_d = PH_STATUS_CR;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_STATUS_CR: begin
          if (b == ChCr) begin
            phase_d = PH_STATUS_LF;
          end
        end
        PH_STATUS_LF: begin
          phase_d = (b == ChLf) ? PH_HDR_START : PH_ERROR;
        end
        PH_HDR_START: begin
          if (b == ChCr) begin
            phase_d = PH_BLANK_LF;
          end else begin
            match_d = (b_low == ChLowC) ? 5'd1 : NoMatch;
            phase_d = PH_HDR_NAME;
          end
        end
        PH_HDR_NAME: begin
          if (b == ChColon) begin
            if (match_q != NameLen) begin
              match_d = NoMatch;
            end
            phase_d = PH_VAL_START;
          end else if (match_q < NameLen && b_low == wanted_char(match_q[3:0])) begin
            match_d = match_q + 5'd1;
          end else begin
            match_d = NoMatch;
          end
        end
        PH_VAL_START, PH_HDR_VALUE: begin
          len_d   = len_base;
          phase_d = PH_HDR_VALUE;
          if (b == ChCr) begin
            phase_d = PH_HDR_LF;
          end else if (match_q == NameLen && is_digit) begin
            len_d = len_next;
          end
        end
        PH_HDR_LF: begin
          phase_d = (b == ChLf) ? PH_HDR_START : PH_ERROR;
          match_d = NoMatch;
        end
        PH_BLANK_LF: begin
          phase_d = (b == ChLf) ? PH_BODY_START : PH_ERROR;
        end
        PH_BODY_START, PH_BODY: begin
          is_body = 1'b1;
          if (phase_q == PH_BODY_START) begin
            unlim_d  = (len_q == '0);
            remain_d = '0;
            phase_d  = PH_BODY;
          end
          if (!unlim_d) begin
            remain_d = rem_dec;
            if (rem_dec == '0) begin
              is_last = 1'b1;
              phase_d = PH_COMPLETE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign len_ext = {32'b0, len_d};

  always_comb begin
    out_item_d.phase          = phase_d;
    out_item_d.status_code    = status_d;
    out_item_d.length_value   = len_ext[31:0];
    out_item_d.is_body_byte   = is_body;
    out_item_d.last_body_byte = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEEK_SPACE;
      match_q     <= NoMatch;
      status_q    <= '0;
      len_q       <= '0;
      remain_q    <= '0;
      unlim_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        match_q  <= match_d;
        status_q <= status_d;
        len_q    <= len_d;
        remain_q <= remain_d;
        unlim_q  <= unlim_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

`default_nettype wire
